// ===== src/efe_pkg.sv =====
`default_nettype none

package efe_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_MARKER      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_MARKER        = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ESCAPE_MARKER     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ESCAPE_RANGE_LOW  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ESCAPE_RANGE_HIGH = 3'd4;

   localparam logic [7:0] START_MARKER_RESET      = 8'd250;
   localparam logic [7:0] END_MARKER_RESET        = 8'd251;
   localparam logic [7:0] ESCAPE_MARKER_RESET     = 8'd252;
   localparam logic [7:0] ESCAPE_RANGE_LOW_RESET  = 8'd248;
   localparam logic [7:0] ESCAPE_RANGE_HIGH_RESET = 8'd255;

   localparam logic [7:0] ESCAPE_OFFSET = 8'h08;
   localparam logic       HIGH_BIT      = 1'b1;

   localparam int unsigned SUM_WIDTH = 14;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] end_marker;
      logic [7:0] escape_marker;
      logic [7:0] escape_range_low;
      logic [7:0] escape_range_high;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        frame_start;
      logic        frame_end;
      logic [13:0] frame_length;
   } item_type;

   typedef enum logic [3:0] {
      PH_START0,
      PH_START1,
      PH_LENGTH0,
      PH_LENGTH1,
      PH_PAYLOAD0,
      PH_PAYLOAD1,
      PH_CHECK0,
      PH_CHECK1,
      PH_END0,
      PH_END1
   } phase_type;

   typedef struct packed {
      logic [7:0]           out_byte;
      logic                 frame_done;
      logic                 item_done;
      phase_type            next_phase;
      logic [SUM_WIDTH-1:0] sum_next;
   } step_type;

endpackage

`default_nettype wire

// ===== src/efe_byte_gen.sv =====
`default_nettype none

module efe_byte_gen
   import efe_pkg::*;
(
   input  wire cfg_type              cfg,
   input  wire item_type             item,
   input  wire phase_type            phase,
   input  wire logic [SUM_WIDTH-1:0] sum,
   output step_type                  step
);

   logic                 escape_hit;
   logic [SUM_WIDTH-1:0] neg_sum;

   assign escape_hit = (item.payload_byte >= cfg.escape_range_low) &&
                       (item.payload_byte <= cfg.escape_range_high);
   assign neg_sum    = '0 - sum;

   always_comb begin
      step.out_byte   = '0;
      step.frame_done = 1'b0;
      step.item_done  = 1'b0;
      step.next_phase = PH_START0;
      step.sum_next   = sum;
      unique case (phase)
         PH_START0: begin
            step.out_byte   = cfg.start_marker;
            step.sum_next   = '0;
            step.next_phase = PH_START1;
         end
         PH_START1: begin
            step.out_byte   = cfg.start_marker;
            step.next_phase = PH_LENGTH0;
         end
         PH_LENGTH0: begin
            step.out_byte   = {HIGH_BIT, item.frame_length[6:0]};
            step.sum_next   = sum + SUM_WIDTH'(step.out_byte);
            step.next_phase = PH_LENGTH1;
         end
         PH_LENGTH1: begin
            step.out_byte   = {HIGH_BIT, item.frame_length[13:7]};
            step.sum_next   = sum + SUM_WIDTH'(step.out_byte);
            step.next_phase = (item.frame_length == '0) ? PH_CHECK0 : PH_PAYLOAD0;
         end
         PH_PAYLOAD0: begin
            step.out_byte = escape_hit ? cfg.escape_marker : item.payload_byte;
            step.sum_next = sum + SUM_WIDTH'(step.out_byte);
            if (escape_hit) begin
               step.next_phase = PH_PAYLOAD1;
            end else if (item.frame_end) begin
               step.next_phase = PH_CHECK0;
            end else begin
               step.item_done = 1'b1;
            end
         end
         PH_PAYLOAD1: begin
            step.out_byte = item.payload_byte + ESCAPE_OFFSET;
            step.sum_next = sum + SUM_WIDTH'(step.out_byte);
            if (item.frame_end) begin
               step.next_phase = PH_CHECK0;
            end else begin
               step.item_done = 1'b1;
            end
         end
         PH_CHECK0: begin
            step.out_byte   = {HIGH_BIT, neg_sum[6:0]};
            step.next_phase = PH_CHECK1;
         end
         PH_CHECK1: begin
            step.out_byte   = {HIGH_BIT, neg_sum[13:7]};
            step.next_phase = PH_END0;
         end
         PH_END0: begin
            step.out_byte   = cfg.end_marker;
            step.next_phase = PH_END1;
         end
         PH_END1: begin
            step.out_byte   = cfg.end_marker;
            step.frame_done = 1'b1;
            step.item_done  = 1'b1;
            step.sum_next   = '0;
         end
         default: begin
            step.item_done = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/escaped_frame_encoder.sv =====
`default_nettype none

// Escaped frame encoder. Each accepted item is held in an input register and
// turned into encoded bytes, one byte per clock into the rsp_ output register
// unless rsp_stall holds it: a plain payload byte yields one byte, an escaped
// one two, the first item of a frame adds four header bytes and the last adds
// four trailer bytes, and an empty frame (frame_start with frame_length zero)
// yields exactly eight. An item therefore yields 1 to 10 bytes, all of which
// pass through the single output byte register. The next item is taken in the
// same cycle that the last byte of the current one enters the output register.
// The marker and escape range registers are written through the csr_ port.

module escaped_frame_encoder
   import efe_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,

   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [7:0]                 csr_data,

   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [7:0]                 req_payload_byte,
   input  wire logic                       req_frame_start,
   input  wire logic                       req_frame_end,
   input  wire logic [13:0]                req_frame_length,

   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_frame_done
);

   cfg_type              cfg_ff;
   item_type             item_ff;
   logic                 item_valid_ff;
   phase_type            phase_ff;
   logic [SUM_WIDTH-1:0] sum_ff;
   logic                 rsp_valid_ff;
   logic [7:0]           rsp_byte_ff;
   logic                 rsp_done_ff;

   step_type             step;
   logic                 out_free;
   logic                 emit;
   logic                 req_take;

   efe_byte_gen u_byte_gen (
      .cfg   (cfg_ff),
      .item  (item_ff),
      .phase (phase_ff),
      .sum   (sum_ff),
      .step  (step)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !(emit && step.item_done);
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_frame_done = rsp_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker      <= START_MARKER_RESET;
         cfg_ff.end_marker        <= END_MARKER_RESET;
         cfg_ff.escape_marker     <= ESCAPE_MARKER_RESET;
         cfg_ff.escape_range_low  <= ESCAPE_RANGE_LOW_RESET;
         cfg_ff.escape_range_high <= ESCAPE_RANGE_HIGH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_MARKER:      cfg_ff.start_marker      <= csr_data;
            CSR_END_MARKER:        cfg_ff.end_marker        <= csr_data;
            CSR_ESCAPE_MARKER:     cfg_ff.escape_marker     <= csr_data;
            CSR_ESCAPE_RANGE_LOW:  cfg_ff.escape_range_low  <= csr_data;
            CSR_ESCAPE_RANGE_HIGH: cfg_ff.escape_range_high <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         phase_ff      <= PH_START0;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_take) begin
            item_valid_ff <= 1'b1;
            phase_ff      <= req_frame_start ? PH_START0 : PH_PAYLOAD0;
         end else if (emit) begin
            item_valid_ff <= !step.item_done;
            phase_ff      <= step.next_phase;
         end
         if (emit) begin
            sum_ff <= step.sum_next;
         end
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.payload_byte <= req_payload_byte;
         item_ff.frame_start  <= req_frame_start;
         item_ff.frame_end    <= req_frame_end;
         item_ff.frame_length <= req_frame_length;
      end
      if (emit) begin
         rsp_byte_ff <= step.out_byte;
         rsp_done_ff <= step.frame_done;
      end
   end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import efe_pkg::*;

   localparam int RANDOM_ITEMS = 145;
   localparam int LIMIT_CYCLES = 400000;
   localparam int LONG_HOLD    = 300;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_done;
   } enc_byte_t;

   typedef struct {
      bit          is_config;
      cfg_type     setting;
      item_type    it;
      int          typed_count;
      logic [79:0] typed_bytes;
      int          done_at;
   } stim_row_t;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [7:0]                 csr_data;
   logic                       req_valid;
   logic                       req_stall;
   logic [7:0]                 req_payload_byte;
   logic                       req_frame_start;
   logic                       req_frame_end;
   logic [13:0]                req_frame_length;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [7:0]                 rsp_out_byte;
   logic                       rsp_frame_done;

   cfg_type     cfg;
   logic [14:0] frame_sum;
   enc_byte_t   step_bytes [$];
   enc_byte_t   expected_bytes [$];
   enc_byte_t   oldest;
   stim_row_t   stimulus_table [$];

   bit quiet_mode;
   bit hold_rsp;
   int error_count;
   int items_sent;
   int random_items;
   int bytes_checked;
   int frames_closed;
   int settings_applied;
   int cycle_count;

   escaped_frame_encoder u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_byte (req_payload_byte),
      .req_frame_start  (req_frame_start),
      .req_frame_end    (req_frame_end),
      .req_frame_length (req_frame_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_done   (rsp_frame_done)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void put_byte(input logic [7:0] b, input logic done);
      step_bytes.push_back('{out_byte: b, frame_done: done});
   endfunction

   function automatic void put_summed(input logic [7:0] b);
      frame_sum = frame_sum + {7'd0, b};
      put_byte(b, 1'b0);
   endfunction

   function automatic void close_frame();
      logic [14:0] neg;
      neg = 15'd0 - frame_sum;
      put_byte({1'b1, neg[6:0]}, 1'b0);
      put_byte({1'b1, neg[13:7]}, 1'b0);
      put_byte(cfg.end_marker, 1'b0);
      put_byte(cfg.end_marker, 1'b1);
      frame_sum = '0;
   endfunction

   function automatic void encode_item(input item_type it);
      step_bytes.delete();
      if (it.frame_start) begin
         frame_sum = '0;
         put_byte(cfg.start_marker, 1'b0);
         put_byte(cfg.start_marker, 1'b0);
         put_summed({1'b1, it.frame_length[6:0]});
         put_summed({1'b1, it.frame_length[13:7]});
         if (it.frame_length == 14'd0) begin
            close_frame();
            return;
         end
      end
      if (it.payload_byte >= cfg.escape_range_low && it.payload_byte <= cfg.escape_range_high) begin
         put_summed(cfg.escape_marker);
         put_summed(it.payload_byte + ESCAPE_OFFSET);
      end else begin
         put_summed(it.payload_byte);
      end
      if (it.frame_end) begin
         close_frame();
      end
   endfunction

   function automatic void add_item(input logic [7:0] b, input logic s, input logic e,
                                    input logic [13:0] len, input int count,
                                    input logic [79:0] bytes, input int done_at);
      stim_row_t row;
      row.is_config   = 1'b0;
      row.setting     = '0;
      row.it          = '{payload_byte: b, frame_start: s, frame_end: e, frame_length: len};
      row.typed_count = count;
      row.typed_bytes = bytes;
      row.done_at     = done_at;
      stimulus_table.push_back(row);
   endfunction

   function automatic void add_config(input cfg_type c);
      stim_row_t row;
      row.is_config   = 1'b1;
      row.setting     = c;
      row.it          = '0;
      row.typed_count = 0;
      row.typed_bytes = '0;
      row.done_at     = -1;
      stimulus_table.push_back(row);
   endfunction

   function automatic logic [7:0] pick_byte();
      if (cfg.escape_range_low <= cfg.escape_range_high && $urandom_range(0, 2) == 0) begin
         return 8'($urandom_range(cfg.escape_range_low, cfg.escape_range_high));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.start_marker  = 8'($urandom_range(0, 255));
      c.end_marker    = 8'($urandom_range(0, 255));
      c.escape_marker = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
         0: begin
            c.escape_range_low  = 8'd0;
            c.escape_range_high = 8'd255;
         end
         1: begin
            c.escape_range_low  = 8'($urandom_range(0, 255));
            c.escape_range_high = c.escape_range_low;
         end
         default: begin
            c.escape_range_low  = 8'($urandom_range(0, 255));
            c.escape_range_high = 8'($urandom_range(0, 255));
         end
      endcase
      return c;
   endfunction

   task automatic send_item(input item_type it, input int typed_count,
                            input logic [79:0] typed_bytes, input int done_at);
      int gap;
      gap = quiet_mode ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_payload_byte <= it.payload_byte;
      req_frame_start  <= it.frame_start;
      req_frame_end    <= it.frame_end;
      req_frame_length <= it.frame_length;
      do @(posedge clock); while (req_stall);
      encode_item(it);
      if (typed_count == 0) begin
         foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
      end else begin
         for (int i = 0; i < typed_count; i++) begin
            expected_bytes.push_back('{out_byte: typed_bytes[79 - 8 * i -: 8],
                                       frame_done: (i == done_at)});
         end
      end
      items_sent++;
   endtask

   task automatic send_frame(input int count);
      item_type it;
      for (int k = 0; k < count; k++) begin
         it.payload_byte = pick_byte();
         it.frame_start  = (k == 0);
         it.frame_end    = (k == count - 1);
         if (k == 0 && $urandom_range(0, 9) < 7) begin
            it.frame_length = 14'(count);
         end else begin
            it.frame_length = 14'($urandom);
         end
         send_item(it, 0, '0, -1);
      end
      random_items += count;
   endtask

   // The block is idle once every expected byte has been transferred.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input cfg_type c);
      logic [CSR_INDEX_WIDTH-1:0] reg_index [5];
      logic [7:0]                 reg_value [5];
      reg_index = '{CSR_START_MARKER, CSR_END_MARKER, CSR_ESCAPE_MARKER,
                    CSR_ESCAPE_RANGE_LOW, CSR_ESCAPE_RANGE_HIGH};
      reg_value = '{c.start_marker, c.end_marker, c.escape_marker,
                    c.escape_range_low, c.escape_range_high};
      for (int k = 0; k < 5; k++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= reg_index[k];
         csr_data         <= reg_value[k];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      cfg = c;
      settings_applied++;
   endtask

   initial begin
      int stall_cycles;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         stall_cycles = quiet_mode ? 0 : $urandom_range(0, 17);
         if (hold_rsp) begin
            stall_cycles = LONG_HOLD;
            hold_rsp     = 1'b0;
         end
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected transfer: out_byte %02h frame_done %0b",
                   rsp_out_byte, rsp_frame_done);
            error_count++;
         end else begin
            oldest = expected_bytes.pop_front();
            if (rsp_out_byte !== oldest.out_byte) begin
               $error("out_byte: expected %02h, actual %02h", oldest.out_byte, rsp_out_byte);
               error_count++;
            end
            if (rsp_frame_done !== oldest.frame_done) begin
               $error("frame_done: expected %0b, actual %0b",
                      oldest.frame_done, rsp_frame_done);
               error_count++;
            end
            bytes_checked++;
            if (rsp_frame_done) frames_closed++;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped after %0d cycles with %0d bytes still expected.",
               cycle_count, expected_bytes.size());
      $display("status: fail");
      $finish;
   end

   initial begin
      item_type it;
      int       choice;
      int       next_setting;

      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_START_MARKER;
      csr_data         <= 8'd0;
      req_valid        <= 1'b0;
      req_payload_byte <= 8'd0;
      req_frame_start  <= 1'b0;
      req_frame_end    <= 1'b0;
      req_frame_length <= 14'd0;
      cfg = '{START_MARKER_RESET, END_MARKER_RESET, ESCAPE_MARKER_RESET,
              ESCAPE_RANGE_LOW_RESET, ESCAPE_RANGE_HIGH_RESET};
      frame_sum        = '0;
      quiet_mode       = 1'b0;
      hold_rsp         = 1'b0;
      error_count      = 0;
      items_sent       = 0;
      random_items     = 0;
      bytes_checked    = 0;
      frames_closed    = 0;
      settings_applied = 0;

      // Reset settings first: an empty frame, a stray byte and an escaped stray byte that
      // closes a frame, then a maximum length header.
      add_item(8'hFF, 1'b1, 1'b1, 14'd0,     8, 80'hFAFA_8080_80FE_FBFB_0000, 7);
      add_item(8'h00, 1'b0, 1'b0, 14'd0,     1, 80'h0000_0000_0000_0000_0000, -1);
      add_item(8'hFF, 1'b0, 1'b1, 14'h3FFF,  6, 80'hFC07_FDFD_FBFB_0000_0000, 5);
      add_item(8'hF8, 1'b1, 1'b0, 14'h3FFF,  6, 80'hFAFA_FFFF_FC00_0000_0000, -1);
      add_item(8'hF7, 1'b0, 1'b0, 14'd0,     0, '0, -1);
      add_item(8'h55, 1'b0, 1'b1, 14'd0,     0, '0, -1);
      add_item(8'h12, 1'b1, 1'b0, 14'd3,     0, '0, -1);
      add_item(8'hFE, 1'b1, 1'b1, 14'd1,     0, '0, -1);
      add_item(8'h80, 1'b0, 1'b0, 14'd0,     0, '0, -1);
      add_item(8'h01, 1'b1, 1'b0, 14'h2AAA,  0, '0, -1);
      add_item(8'hAA, 1'b0, 1'b0, 14'h1555,  0, '0, -1);
      add_item(8'h54, 1'b0, 1'b1, 14'd0,     0, '0, -1);
      add_item(8'hFB, 1'b1, 1'b1, 14'h1555,  0, '0, -1);
      add_config('{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00});
      add_item(8'h00, 1'b1, 1'b0, 14'd2,     0, '0, -1);
      add_item(8'hFF, 1'b0, 1'b1, 14'd0,     0, '0, -1);
      add_item(8'h00, 1'b1, 1'b1, 14'd0,     0, '0, -1);
      // With the low bound above the high bound nothing is escaped.
      add_config('{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00});
      add_item(8'hFF, 1'b1, 1'b0, 14'd5,     0, '0, -1);
      add_item(8'h00, 1'b0, 1'b0, 14'd0,     0, '0, -1);
      add_item(8'h80, 1'b0, 1'b1, 14'd0,     0, '0, -1);
      add_config('{8'h7E, 8'h7D, 8'h7D, 8'h00, 8'hFF});
      add_item(8'hFF, 1'b1, 1'b0, 14'h3FFF,  0, '0, -1);
      add_item(8'h00, 1'b0, 1'b1, 14'd0,     0, '0, -1);
      add_item(8'hF8, 1'b0, 1'b1, 14'd0,     0, '0, -1);
      add_config('{8'h01, 8'hFE, 8'h80, 8'hFF, 8'hFF});
      add_item(8'hFF, 1'b1, 1'b1, 14'd1,     0, '0, -1);
      add_item(8'hFE, 1'b1, 1'b1, 14'd1,     0, '0, -1);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stimulus_table[r]) begin
         if (stimulus_table[r].is_config) begin
            settle();
            configure(stimulus_table[r].setting);
         end else begin
            send_item(stimulus_table[r].it, stimulus_table[r].typed_count,
                      stimulus_table[r].typed_bytes, stimulus_table[r].done_at);
         end
      end

      // The receiver holds off while a back-to-back frame fills the block.
      settle();
      configure(random_cfg());
      quiet_mode = 1'b1;
      hold_rsp   = 1'b1;
      send_frame(16);
      quiet_mode = 1'b0;

      next_setting = 45;
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= next_setting) begin
            settle();
            configure(random_cfg());
            next_setting += 45;
         end
         quiet_mode = ($urandom_range(0, 4) == 0);
         choice = $urandom_range(0, 9);
         if (choice < 7) begin
            send_frame(($urandom_range(0, 5) == 0) ? $urandom_range(7, 12)
                                                    : $urandom_range(1, 6));
         end else begin
            it = 24'($urandom);
            if (choice == 7) begin
               it.frame_start  = 1'b1;
               it.frame_length = 14'd0;
            end
            send_item(it, 0, '0, -1);
            random_items++;
         end
      end
      quiet_mode = 1'b0;

      settle();
      repeat (20) @(posedge clock);
      $display("Sent %0d items under %0d marker and escape settings.",
               items_sent, settings_applied + 1);
      $display("Checked %0d encoded bytes across %0d closed frames, %0d mismatches.",
               bytes_checked, frames_closed, error_count);
      if (error_count == 0 && expected_bytes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/efe_pkg.sv
src/efe_byte_gen.sv
src/escaped_frame_encoder.sv
test/tb_top.sv
